>>> hdl/oprs_pkg.sv
// shared types and constants for the oled page refresh sequencer
// no dependencies
package oprs_pkg;

    localparam int PAGES       = 8;
    localparam int COLUMNS     = 128;
    localparam int STORE_DEPTH = PAGES * COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int HEAD_STEPS  = 3;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] FILL_ONES     = 8'hFF;
    localparam logic [7:0] FILL_ZEROS    = 8'h00;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_REFRESH    = 3'd2,
        OP_FILL_ZEROS = 3'd3,
        OP_FILL_ONES  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        SRC_STORE = 2'd0,
        SRC_ZEROS = 2'd1,
        SRC_ONES  = 2'd2
    } t_src;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_FETCH = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic clear_en;
        logic load_data;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic data_tick;
        logic out_valid;
    } t_dp_status;

endpackage

>>> hdl/oled_page_refresh_sequencer_core.sv
// oled page refresh sequencer, top level
// output path: command bytes go straight to the output register; data bytes first
// pass the registered store read. throughput: one beat per cycle while the output
// is not stalled; a data tick holds off the next beat until its store read is done,
// writes and starts do not. reset: synchronous; then a clearing pass zeros the
// frame store, with o_in_stall held high until it finishes
module oled_page_refresh_sequencer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  oprs_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output oprs_pkg::t_out_item  o_out_item
);
    import oprs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    oprs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    oprs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> hdl/oprs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module oprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/oprs_ctrl.sv
// control state machine: clear pass, item acceptance, store fetch
// depends on oprs_pkg
module oprs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  oprs_pkg::t_dp_status i_status,
    output logic               o_in_stall,
    output oprs_pkg::t_dp_cmd  o_cmd
);
    import oprs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   can_take;

    // the output register must be empty or draining before a beat is taken
    assign can_take = !i_status.out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && can_take && i_status.data_tick) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_stall      = 1'b1;
        o_cmd.accept    = 1'b0;
        o_cmd.clear_en  = 1'b0;
        o_cmd.load_data = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall   = !can_take;
                o_cmd.accept = i_in_valid && can_take;
            end
            ST_FETCH: begin
                o_cmd.load_data = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/oprs_datapath.sv
// frame store, refresh counters and output register
// depends on oprs_pkg and oprs_ram
module oprs_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  oprs_pkg::t_in_item    i_in_item,
    input  logic                  i_out_stall,
    input  oprs_pkg::t_dp_cmd     i_cmd,
    output oprs_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output oprs_pkg::t_out_item   o_out_item
);
    import oprs_pkg::*;

    logic              r_busy;
    t_src              r_src;
    logic [2:0]        r_page;
    logic [7:0]        r_step;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic              r_out_valid;
    t_out_item         r_out;
    t_src              r_fetch_src;
    logic              r_fetch_end;

    t_op               op;
    logic              is_tick;
    logic              is_cmd_tick;
    logic              is_data_tick;
    logic              is_start;
    logic              wr_ok;
    logic              step_last;
    logic              page_last;
    logic [COL_W-1:0]  data_col;
    logic [ADDR_W-1:0] data_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [7:0]        cmd_byte;
    t_src              start_src;

    assign op           = t_op'(i_in_item.operation);
    assign is_tick      = (op == OP_TICK) && r_busy;
    assign is_data_tick = is_tick && (r_step >= 8'(HEAD_STEPS));
    assign is_cmd_tick  = is_tick && !is_data_tick;
    assign is_start     = ((op == OP_REFRESH) || (op == OP_FILL_ZEROS) ||
                           (op == OP_FILL_ONES)) && !r_busy;
    assign wr_ok        = (op == OP_WRITE) && !r_busy &&
                          (int'(i_in_item.page) < PAGES) &&
                          (int'(i_in_item.column) < COLUMNS);

    assign step_last = r_step == 8'(HEAD_STEPS + COLUMNS - 1);
    assign page_last = r_page == 3'(PAGES - 1);

    assign data_col  = COL_W'(r_step - 8'(HEAD_STEPS));
    assign data_addr = ADDR_W'(int'(r_page) * COLUMNS + int'(data_col));
    assign wr_addr   = ADDR_W'(int'(i_in_item.page) * COLUMNS + int'(i_in_item.column));

    always_comb begin
        case (op)
            OP_FILL_ZEROS: start_src = SRC_ZEROS;
            OP_FILL_ONES:  start_src = SRC_ONES;
            default:       start_src = SRC_STORE;
        endcase
    end

    always_comb begin
        case (r_step)
            8'd0:    cmd_byte = CMD_PAGE_BASE + {5'd0, r_page};
            8'd1:    cmd_byte = CMD_COL_LOW;
            default: cmd_byte = CMD_COL_HIGH;
        endcase
    end

    // store port: clear pass, byte write, or clear-on-read during a refresh
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_cnt;
        ram_wdata = 8'd0;
        if (i_cmd.clear_en) begin
            ram_we = 1'b1;
        end else if (i_cmd.accept && wr_ok) begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr;
            ram_wdata = i_in_item.value;
        end else if (i_cmd.accept && is_data_tick && (r_src == SRC_STORE)) begin
            ram_we    = 1'b1;
            ram_waddr = data_addr;
        end
    end

    oprs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (data_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_src       <= SRC_STORE;
            r_page      <= 3'd0;
            r_step      <= 8'd0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.accept && is_start) begin
                r_busy <= 1'b1;
                r_src  <= start_src;
                r_page <= 3'd0;
                r_step <= 8'd0;
            end else if (i_cmd.accept && is_tick) begin
                if (step_last) begin
                    r_step <= 8'd0;
                    if (page_last) begin
                        r_page <= 3'd0;
                        r_busy <= 1'b0;
                    end else begin
                        r_page <= r_page + 3'd1;
                    end
                end else begin
                    r_step <= r_step + 8'd1;
                end
            end
            if ((i_cmd.accept && is_cmd_tick) || i_cmd.load_data) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_cmd_tick) begin
            r_out.out_byte   <= cmd_byte;
            r_out.is_command <= 1'b1;
            r_out.frame_end  <= 1'b0;
        end else if (i_cmd.load_data) begin
            case (r_fetch_src)
                SRC_ZEROS: r_out.out_byte <= FILL_ZEROS;
                SRC_ONES:  r_out.out_byte <= FILL_ONES;
                default:   r_out.out_byte <= ram_rdata;
            endcase
            r_out.is_command <= 1'b0;
            r_out.frame_end  <= r_fetch_end;
        end
        if (i_cmd.accept && is_data_tick) begin
            r_fetch_src <= r_src;
            r_fetch_end <= page_last && step_last;
        end
    end

    assign o_status.clear_last = r_clr_cnt == ADDR_W'(STORE_DEPTH - 1);
    assign o_status.data_tick  = is_data_tick;
    assign o_status.out_valid  = r_out_valid;
    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out;

endmodule
